// ===== hdl/amc_pkg.sv =====
package amc_pkg;

    // signed fixed-point coefficient and its one-bit-wider form (holds -(-2^31))
    typedef logic signed [31:0] t_q;
    typedef logic signed [32:0] t_qw;

    localparam t_q Q_MAX = 32'sh7fff_ffff;
    localparam t_q Q_MIN = 32'sh8000_0000;

    typedef enum logic [2:0] {
        OP_IDENTITY  = 3'd0,
        OP_LOAD      = 3'd1,
        OP_QUARTER   = 3'd2,
        OP_ROT_MOVE  = 3'd3,
        OP_TRANSLATE = 3'd4,
        OP_SCALE     = 3'd5,
        OP_MULTIPLY  = 3'd6,
        OP_ANGLE     = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        QT_0   = 2'd0,
        QT_90  = 2'd1,
        QT_180 = 2'd2,
        QT_270 = 2'd3
    } t_qt;

    typedef struct packed {
        t_q a;
        t_q b;
        t_q c;
        t_q d;
        t_q e;
        t_q f;
    } t_mat;

    typedef struct packed {
        t_op op;
        t_qt qt;
        t_q  v0;
        t_q  v1;
        t_q  v2;
        t_q  v3;
        t_q  v4;
        t_q  v5;
    } t_item;

endpackage

// ===== hdl/amc_quarter.sv =====
module amc_quarter (
    input  amc_pkg::t_q  i_a,
    input  amc_pkg::t_q  i_b,
    input  amc_pkg::t_q  i_c,
    input  amc_pkg::t_q  i_d,
    input  amc_pkg::t_qt i_qt,
    output amc_pkg::t_q  o_a,
    output amc_pkg::t_q  o_b,
    output amc_pkg::t_q  o_c,
    output amc_pkg::t_q  o_d,
    output logic         o_sat
);
    import amc_pkg::*;

    // negation clamps the minimum to the maximum
    function automatic t_q neg_sat(input t_q x);
        neg_sat = (x == Q_MIN) ? Q_MAX : -x;
    endfunction

    logic min_a, min_b, min_c, min_d;

    assign min_a = (i_a == Q_MIN);
    assign min_b = (i_b == Q_MIN);
    assign min_c = (i_c == Q_MIN);
    assign min_d = (i_d == Q_MIN);

    always_comb begin
        o_a   = i_a;
        o_b   = i_b;
        o_c   = i_c;
        o_d   = i_d;
        o_sat = 1'b0;
        unique case (i_qt)
            QT_0: begin
            end
            QT_90: begin
                o_a   = i_c;
                o_b   = i_d;
                o_c   = neg_sat(i_a);
                o_d   = neg_sat(i_b);
                o_sat = min_a | min_b;
            end
            QT_180: begin
                o_a   = neg_sat(i_a);
                o_b   = neg_sat(i_b);
                o_c   = neg_sat(i_c);
                o_d   = neg_sat(i_d);
                o_sat = min_a | min_b | min_c | min_d;
            end
            QT_270: begin
                o_a   = neg_sat(i_c);
                o_b   = neg_sat(i_d);
                o_c   = i_a;
                o_d   = i_b;
                o_sat = min_c | min_d;
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== hdl/amc_dot2.sv =====
module amc_dot2 #(
    parameter int FRAC_BITS = 16
) (
    input  amc_pkg::t_q  i_x1,
    input  amc_pkg::t_qw i_y1,
    input  amc_pkg::t_q  i_x2,
    input  amc_pkg::t_qw i_y2,
    input  amc_pkg::t_q  i_add,
    output amc_pkg::t_q  o_res,
    output logic         o_sat
);
    import amc_pkg::*;

    logic signed [64:0] prod1;
    logic signed [64:0] prod2;
    logic signed [65:0] sum;
    logic signed [65:0] sum_sh;
    logic signed [66:0] total;
    logic        [35:0] top_bits;

    assign prod1    = 65'(i_x1) * 65'(i_y1);
    assign prod2    = 65'(i_x2) * 65'(i_y2);
    assign sum      = 66'(prod1) + 66'(prod2);
    // arithmetic shift gives floor rounding of the exact sum
    assign sum_sh   = sum >>> FRAC_BITS;
    assign total    = 67'(sum_sh) + 67'(i_add);
    assign top_bits = total[66:31];
    assign o_sat    = !((&top_bits) || !(|top_bits));
    assign o_res    = o_sat ? (total[66] ? Q_MIN : Q_MAX) : total[31:0];

endmodule

// ===== hdl/amc_update.sv =====
module amc_update #(
    parameter int FRAC_BITS = 16
) (
    input  amc_pkg::t_item i_item,
    input  amc_pkg::t_mat  i_mat,
    output amc_pkg::t_mat  o_mat,
    output logic           o_sat
);
    import amc_pkg::*;

    localparam t_q ONE = 32'sd1 <<< FRAC_BITS;

    t_q   qa, qb, qc, qd;
    logic qsat;
    t_q   xa, xb, xc, xd;
    t_q   x1 [6];
    t_q   x2 [6];
    t_qw  y1 [6];
    t_qw  y2 [6];
    t_q   add [6];
    t_q   res [6];
    logic [5:0] dsat;
    t_qw  v0w, v1w, v2w, v3w, v4w, v5w;

    amc_quarter u_quarter (
        .i_a   (i_mat.a),
        .i_b   (i_mat.b),
        .i_c   (i_mat.c),
        .i_d   (i_mat.d),
        .i_qt  (i_item.qt),
        .o_a   (qa),
        .o_b   (qb),
        .o_c   (qc),
        .o_d   (qd),
        .o_sat (qsat)
    );

    assign v0w = 33'(i_item.v0);
    assign v1w = 33'(i_item.v1);
    assign v2w = 33'(i_item.v2);
    assign v3w = 33'(i_item.v3);
    assign v4w = 33'(i_item.v4);
    assign v5w = 33'(i_item.v5);

    // rotate-then-move translates the already turned matrix
    assign xa = (i_item.op == OP_ROT_MOVE) ? qa : i_mat.a;
    assign xb = (i_item.op == OP_ROT_MOVE) ? qb : i_mat.b;
    assign xc = (i_item.op == OP_ROT_MOVE) ? qc : i_mat.c;
    assign xd = (i_item.op == OP_ROT_MOVE) ? qd : i_mat.d;

    // units 0..5 produce a..f; even units use the a/c column, odd ones b/d
    always_comb begin
        for (int k = 0; k < 6; k++) begin
            x1[k] = (k % 2 == 0) ? xa : xb;
            x2[k] = (k % 2 == 0) ? xc : xd;
            y1[k] = '0;
            y2[k] = '0;
            add[k] = '0;
        end
        add[4] = i_mat.e;
        add[5] = i_mat.f;
        unique case (i_item.op)
            OP_ROT_MOVE: begin
                unique case (i_item.qt)
                    QT_90: begin
                        y1[4] = v0w;
                        y1[5] = v0w;
                    end
                    QT_180: begin
                        y1[4] = v0w;
                        y1[5] = v0w;
                        y2[4] = v1w;
                        y2[5] = v1w;
                    end
                    QT_270: begin
                        y2[4] = v1w;
                        y2[5] = v1w;
                    end
                    default: begin
                    end
                endcase
            end
            OP_TRANSLATE: begin
                y1[4] = v0w;
                y1[5] = v0w;
                y2[4] = v1w;
                y2[5] = v1w;
            end
            OP_SCALE: begin
                y1[0] = v0w;
                y1[1] = v0w;
                y2[2] = v1w;
                y2[3] = v1w;
            end
            OP_MULTIPLY: begin
                y1[0] = v0w;
                y2[0] = v1w;
                y1[1] = v0w;
                y2[1] = v1w;
                y1[2] = v2w;
                y2[2] = v3w;
                y1[3] = v2w;
                y2[3] = v3w;
                y1[4] = v4w;
                y2[4] = v5w;
                y1[5] = v4w;
                y2[5] = v5w;
            end
            OP_ANGLE: begin
                // matrix [cos sin -sin cos 0 0], -sin kept at full width
                y1[0] = v0w;
                y2[0] = v1w;
                y1[1] = v0w;
                y2[1] = v1w;
                y1[2] = -v1w;
                y2[2] = v0w;
                y1[3] = -v1w;
                y2[3] = v0w;
            end
            default: begin
            end
        endcase
    end

    for (genvar gi = 0; gi < 6; gi++) begin : g_dot
        amc_dot2 #(
            .FRAC_BITS (FRAC_BITS)
        ) u_dot (
            .i_x1  (x1[gi]),
            .i_y1  (y1[gi]),
            .i_x2  (x2[gi]),
            .i_y2  (y2[gi]),
            .i_add (add[gi]),
            .o_res (res[gi]),
            .o_sat (dsat[gi])
        );
    end

    always_comb begin
        o_mat = i_mat;
        o_sat = 1'b0;
        unique case (i_item.op)
            OP_IDENTITY: begin
                o_mat = '{a: ONE, b: '0, c: '0, d: ONE, e: '0, f: '0};
            end
            OP_LOAD: begin
                o_mat = '{a: i_item.v0, b: i_item.v1, c: i_item.v2,
                          d: i_item.v3, e: i_item.v4, f: i_item.v5};
            end
            OP_QUARTER: begin
                o_mat.a = qa;
                o_mat.b = qb;
                o_mat.c = qc;
                o_mat.d = qd;
                o_sat   = qsat;
            end
            OP_ROT_MOVE: begin
                o_mat.a = qa;
                o_mat.b = qb;
                o_mat.c = qc;
                o_mat.d = qd;
                o_mat.e = res[4];
                o_mat.f = res[5];
                o_sat   = qsat | dsat[4] | dsat[5];
            end
            OP_TRANSLATE: begin
                o_mat.e = res[4];
                o_mat.f = res[5];
                o_sat   = dsat[4] | dsat[5];
            end
            OP_SCALE: begin
                o_mat.a = res[0];
                o_mat.b = res[1];
                o_mat.c = res[2];
                o_mat.d = res[3];
                o_sat   = |dsat[3:0];
            end
            OP_MULTIPLY, OP_ANGLE: begin
                o_mat = '{a: res[0], b: res[1], c: res[2],
                          d: res[3], e: res[4], f: res[5]};
                o_sat = |dsat;
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== hdl/affine_matrix_composer.sv =====
// channel  | dir | tdata (low bit up)                          | tuser (low bit up)
// ---------+-----+---------------------------------------------+----------------------------
// s (in)   | in  | value_0..value_5, 32 bits each, 192 bits    | op[2:0], quarter_turns[4:3]
// m (out)  | out | coef_a..coef_f, 32 bits each, 192 bits      | saturated[0]
//
// one beat in and one beat out per cycle when both sides flow; a beat passes the
// input register, then the matrix/result register
// the held matrix is the result register, so each op sees the matrix left by the one before
// reset (synchronous, active low) loads the identity matrix and empties both stages
// a stalled output holds the matrix; the input register then fills and tready drops
module affine_matrix_composer #(
    parameter int FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [191:0] i_s_tdata,   // value_0, value_1, value_2, value_3, value_4, value_5
    input  logic [4:0]   i_s_tuser,   // op, quarter_turns
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [191:0] o_m_tdata,   // coef_a, coef_b, coef_c, coef_d, coef_e, coef_f
    output logic [0:0]   o_m_tuser    // saturated
);
    import amc_pkg::*;

    localparam t_q ONE = 32'sd1 <<< FRAC_BITS;

    // input stage
    t_item r_in;
    logic  r_in_valid;
    logic  n_in_valid;
    // matrix state doubles as the result register
    t_mat  r_coef;
    t_mat  n_coef;
    logic  r_sat;
    logic  r_out_valid;
    logic  n_out_valid;

    t_item s_item;
    t_mat  upd_mat;
    logic  upd_sat;
    logic  advance;
    logic  in_take;

    // unpack the incoming beat
    assign s_item = '{op: t_op'(i_s_tuser[2:0]), qt: t_qt'(i_s_tuser[4:3]),
                      v0: i_s_tdata[31:0],    v1: i_s_tdata[63:32],
                      v2: i_s_tdata[95:64],   v3: i_s_tdata[127:96],
                      v4: i_s_tdata[159:128], v5: i_s_tdata[191:160]};

    // an item moves on when the result slot is empty or being drained
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign in_take    = i_s_tvalid && o_s_tready;

    amc_update #(
        .FRAC_BITS (FRAC_BITS)
    ) u_update (
        .i_item (r_in),
        .i_mat  (r_coef),
        .o_mat  (upd_mat),
        .o_sat  (upd_sat)
    );

    always_comb begin
        n_in_valid  = r_in_valid;
        n_out_valid = r_out_valid;
        n_coef      = r_coef;
        if (in_take) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
        if (advance) begin
            n_out_valid = 1'b1;
            n_coef      = upd_mat;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_coef      <= '{a: ONE, b: '0, c: '0, d: ONE, e: '0, f: '0};
            r_sat       <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            r_coef      <= n_coef;
            if (advance) begin
                r_sat <= upd_sat;
            end
        end
    end

    // input payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= s_item;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_coef.f, r_coef.e, r_coef.d, r_coef.c, r_coef.b, r_coef.a};
    assign o_m_tuser  = r_sat;

endmodule

// ===== dv/tb_affine_matrix_composer.sv =====
module tb_affine_matrix_composer;

    timeunit 1ns;
    timeprecision 1ps;

    import amc_pkg::*;

    localparam int FRAC = 16;
    localparam t_q ONE = t_q'(1 << FRAC);

    // per stall mode: percent of cycles the sender idles / the receiver stalls
    localparam int SEND_IDLE [4] = '{0, 54, 0, 30};
    localparam int RECV_STALL [4] = '{0, 0, 54, 30};

    // products of two coefficients (one may be +2^31) plus a sum, with headroom
    typedef logic signed [67:0] t_wide;

    // one pending input beat and the stall mode it is sent under
    typedef struct {
        t_item     beat;
        logic [1:0] mode;
    } t_pending_beat;

    // expected output beat: coef[0] is a, coef[5] is f
    typedef struct packed {
        logic [5:0][31:0] coef;
        logic             sat;
    } t_matrix_beat;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [191:0] i_s_tdata = '0;   // value_0 .. value_5, value_0 lowest
    logic [4:0]   i_s_tuser = '0;   // op[2:0], quarter_turns[4:3]
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [191:0] o_m_tdata;        // coef_a .. coef_f, coef_a lowest
    logic [0:0]   o_m_tuser;        // saturated

    t_pending_beat pending_beats[$];
    t_matrix_beat  expected_mats[$];
    t_q            held [6];         // predicted matrix a..f
    logic [1:0]    cur_mode = '0;
    int            mismatch_count = 0;
    int            result_count = 0;

    affine_matrix_composer u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #4 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // matrix predictor
    // ---------------------------------------------------------------

    // clamp to the signed 32-bit range, raising the saturation flag
    function automatic t_q clamp_q(input t_wide v, inout logic hit);
        if (v > t_wide'(Q_MAX)) begin
            hit = 1'b1;
            return Q_MAX;
        end
        if (v < t_wide'(Q_MIN)) begin
            hit = 1'b1;
            return Q_MIN;
        end
        return t_q'(v);
    endfunction

    // exact two-term dot product, then floor shift (arithmetic shift floors)
    function automatic t_wide dot_floor(input t_wide x1, input t_wide y1,
                                        input t_wide x2, input t_wide y2);
        t_wide sum;
        sum = x1 * y1 + x2 * y2;
        return sum >>> FRAC;
    endfunction

    // M = M * R for a counterclockwise quarter turn; negation is done wide
    function automatic void turn_quarter(input t_qt qt, inout logic hit);
        t_wide a, b, c, d, na, nb, nc, nd;
        a = held[0];
        b = held[1];
        c = held[2];
        d = held[3];
        na = a;
        nb = b;
        nc = c;
        nd = d;
        case (qt)
            QT_90: begin
                na = c;
                nb = d;
                nc = -a;
                nd = -b;
            end
            QT_180: begin
                na = -a;
                nb = -b;
                nc = -c;
                nd = -d;
            end
            QT_270: begin
                na = -c;
                nb = -d;
                nc = a;
                nd = b;
            end
            default: ;
        endcase
        held[0] = clamp_q(na, hit);
        held[1] = clamp_q(nb, hit);
        held[2] = clamp_q(nc, hit);
        held[3] = clamp_q(nd, hit);
    endfunction

    function automatic void move_origin(input t_wide tx, input t_wide ty, inout logic hit);
        t_wide a, b, c, d, e, f;
        a = held[0];
        b = held[1];
        c = held[2];
        d = held[3];
        e = held[4];
        f = held[5];
        held[4] = clamp_q(e + dot_floor(a, tx, c, ty), hit);
        held[5] = clamp_q(f + dot_floor(b, tx, d, ty), hit);
    endfunction

    // M = M * N, every new coefficient from the old matrix
    function automatic void post_multiply(input t_wide r [6], inout logic hit);
        t_wide a, b, c, d, e, f;
        a = held[0];
        b = held[1];
        c = held[2];
        d = held[3];
        e = held[4];
        f = held[5];
        held[0] = clamp_q(dot_floor(a, r[0], c, r[1]), hit);
        held[1] = clamp_q(dot_floor(b, r[0], d, r[1]), hit);
        held[2] = clamp_q(dot_floor(a, r[2], c, r[3]), hit);
        held[3] = clamp_q(dot_floor(b, r[2], d, r[3]), hit);
        held[4] = clamp_q(dot_floor(a, r[4], c, r[5]) + e, hit);
        held[5] = clamp_q(dot_floor(b, r[4], d, r[5]) + f, hit);
    endfunction

    // apply one accepted beat to the held matrix and return the expected output
    function automatic t_matrix_beat compose_step(input t_item it);
        t_wide        v0, v1;
        t_wide        r [6];
        logic         hit;
        t_matrix_beat res;
        hit = 1'b0;
        v0 = it.v0;
        v1 = it.v1;
        case (it.op)
            OP_IDENTITY: held = '{ONE, 0, 0, ONE, 0, 0};
            OP_LOAD:     held = '{it.v0, it.v1, it.v2, it.v3, it.v4, it.v5};
            OP_QUARTER:  turn_quarter(it.qt, hit);
            OP_ROT_MOVE: begin
                turn_quarter(it.qt, hit);
                // move by page width, height or both, depending on the turn
                case (it.qt)
                    QT_90:   move_origin(v0, 0, hit);
                    QT_180:  move_origin(v0, v1, hit);
                    QT_270:  move_origin(0, v1, hit);
                    default: ;
                endcase
            end
            OP_TRANSLATE: move_origin(v0, v1, hit);
            OP_SCALE: begin
                held[0] = clamp_q((t_wide'(held[0]) * v0) >>> FRAC, hit);
                held[1] = clamp_q((t_wide'(held[1]) * v0) >>> FRAC, hit);
                held[2] = clamp_q((t_wide'(held[2]) * v1) >>> FRAC, hit);
                held[3] = clamp_q((t_wide'(held[3]) * v1) >>> FRAC, hit);
            end
            OP_MULTIPLY: begin
                r = '{v0, v1, t_wide'(it.v2), t_wide'(it.v3), t_wide'(it.v4), t_wide'(it.v5)};
                post_multiply(r, hit);
            end
            default: begin
                // angle rotate; -sin is kept wide, so a minimum sine becomes +2^31
                r = '{v0, v1, -v1, v0, 0, 0};
                post_multiply(r, hit);
            end
        endcase
        for (int i = 0; i < 6; i++)
            res.coef[i] = held[i];
        res.sat = hit;
        return res;
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    function automatic void add_beat(input t_op op, input t_qt qt, input logic [1:0] mode,
                                     input t_q v0 = 0, input t_q v1 = 0, input t_q v2 = 0,
                                     input t_q v3 = 0, input t_q v4 = 0, input t_q v5 = 0);
        t_pending_beat pb;
        pb.beat = '{op: op, qt: qt, v0: v0, v1: v1, v2: v2, v3: v3, v4: v4, v5: v5};
        pb.mode = mode;
        pending_beats.push_back(pb);
    endfunction

    // mostly modest fixed-point values so the matrix stays interesting,
    // with full-range and extreme values mixed in
    function automatic t_q rand_coef();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return t_q'(int'($urandom_range(0, 32'h0006_0000)) - 32'h0003_0000);
            4:          return t_q'(int'(ONE) + int'($urandom_range(0, 2048)) - 1024);
            5, 6:       return t_q'($urandom());
            7:          return Q_MAX;
            8:          return Q_MIN;
            default:    return t_q'(int'($urandom_range(0, 64)) - 32);
        endcase
    endfunction

    // ---------------------------------------------------------------
    // input driver: retires the accepted beat, then offers the next one
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_pending_beat nxt;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || o_s_tready) begin
            // beat taken at this edge: predict its result
            if (i_s_tvalid)
                expected_mats.push_back(compose_step(t_item'({i_s_tuser[2:0], i_s_tuser[4:3],
                    i_s_tdata[31:0], i_s_tdata[63:32], i_s_tdata[95:64],
                    i_s_tdata[127:96], i_s_tdata[159:128], i_s_tdata[191:160]})));
            if (pending_beats.size() != 0 &&
                $urandom_range(0, 99) >= SEND_IDLE[pending_beats[0].mode]) begin
                nxt = pending_beats.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tuser  <= {nxt.beat.qt, nxt.beat.op};
                i_s_tdata  <= {nxt.beat.v5, nxt.beat.v4, nxt.beat.v3,
                               nxt.beat.v2, nxt.beat.v1, nxt.beat.v0};
                cur_mode   <= nxt.mode;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // output monitor and receiver stalls
    // ---------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on beat %0d: %s got %h want %h",
                 $realtime, result_count, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_matrix_beat want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (expected_mats.size() == 0) begin
                    report_mismatch("beat with nothing pending", o_m_tdata[31:0], '0);
                end else begin
                    want = expected_mats.pop_front();
                    for (int i = 0; i < 6; i++)
                        if (o_m_tdata[32*i +: 32] !== want.coef[i])
                            report_mismatch($sformatf("coef_%c", 8'h61 + i),
                                            o_m_tdata[32*i +: 32], want.coef[i]);
                    if (o_m_tuser[0] !== want.sat)
                        report_mismatch("saturated", 32'(o_m_tuser[0]), 32'(want.sat));
                end
                result_count++;
            end
            i_m_tready <= ($urandom_range(0, 99) >= RECV_STALL[cur_mode]);
        end
    end

    // ---------------------------------------------------------------
    // test sequence
    // ---------------------------------------------------------------
    initial begin
        held = '{ONE, 0, 0, ONE, 0, 0};

        // directed: every op, all turns, extremes and rounding corners
        add_beat(OP_IDENTITY, QT_270, 0, Q_MAX, Q_MIN, 32'h1234_5678);
        add_beat(OP_TRANSLATE, QT_0, 0, 32'h0001_8000, 32'hfffd_c000);
        add_beat(OP_QUARTER, QT_90, 0);
        add_beat(OP_QUARTER, QT_180, 0);
        add_beat(OP_QUARTER, QT_270, 0);
        add_beat(OP_QUARTER, QT_0, 0, Q_MAX, Q_MAX);
        add_beat(OP_ROT_MOVE, QT_90, 0, 32'h0264_0000, 32'h0318_0000);
        add_beat(OP_ROT_MOVE, QT_180, 0, 32'h0264_0000, 32'h0318_0000);
        add_beat(OP_ROT_MOVE, QT_270, 0, 32'h0264_0000, 32'h0318_0000);
        add_beat(OP_ROT_MOVE, QT_0, 0, 32'h0264_0000, 32'h0318_0000);
        add_beat(OP_SCALE, QT_180, 0, 32'h0002_0000, 32'hffff_8000);
        add_beat(OP_MULTIPLY, QT_90, 0, 32'h0000_c000, 32'h0000_4000, 32'hffff_0000,
                 32'h0001_8000, 32'h000a_0000, 32'hfff6_0000);
        // cosine 0.6, sine 0.8
        add_beat(OP_ANGLE, QT_0, 0, 32'h0000_999a, 32'h0000_cccd);
        // a tiny negative coefficient: the shift must round toward minus infinity
        add_beat(OP_LOAD, QT_0, 0, 32'hffff_ffff, 32'h0000_0001, 32'hffff_fffd, 32'h0000_0003);
        add_beat(OP_TRANSLATE, QT_0, 0, 32'h0000_0001, 32'h0000_0001);
        // negating the minimum coefficient clamps and flags
        add_beat(OP_LOAD, QT_0, 0, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX);
        add_beat(OP_QUARTER, QT_180, 0);
        add_beat(OP_QUARTER, QT_90, 0);
        add_beat(OP_SCALE, QT_0, 0, Q_MAX, Q_MIN);
        add_beat(OP_TRANSLATE, QT_0, 0, Q_MIN, Q_MIN);
        add_beat(OP_MULTIPLY, QT_0, 0, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        // minimum sine, maximum cosine on the identity
        add_beat(OP_IDENTITY, QT_0, 0);
        add_beat(OP_ANGLE, QT_0, 0, Q_MAX, Q_MIN);
        add_beat(OP_ROT_MOVE, QT_180, 0, Q_MAX, Q_MIN);
        add_beat(OP_IDENTITY, QT_0, 0);

        // random: one phase per stall mode
        for (int mode = 0; mode < 4; mode++) begin
            for (int n = 0; n < 200; n++) begin
                t_op  op;
                int   roll;
                roll = $urandom_range(0, 19);
                if (roll == 0)
                    op = OP_IDENTITY;
                else if (roll <= 3)
                    op = OP_LOAD;
                else
                    op = t_op'($urandom_range(2, 7));
                add_beat(op, t_qt'($urandom_range(0, 3)), mode[1:0], rand_coef(), rand_coef(),
                         rand_coef(), rand_coef(), rand_coef(), rand_coef());
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_beats.size() != 0 || i_s_tvalid || expected_mats.size() != 0)
            @(posedge i_clk);
        // output register latency, plus room for any stray beat
        repeat (8) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
